// File: design/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// shared constants and control types for the point-to-segment distance block
// ----------------------------------------------------------------------------
package psd_pkg;

  // default geometry of the block
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // fixed result field widths
  localparam int DIST_W = 41;
  localparam int PROJ_W = 17;

  // control that travels alongside each transaction
  typedef struct packed {
    logic valid;
    logic degen;     // endpoints coincide
    logic clamp_lo;  // projection at or before the start point
    logic clamp_hi;  // projection at or beyond the end point
  } psd_ctrl_t;

endpackage

// File: design/point_segment_distance_sq_top.sv
// ----------------------------------------------------------------------------
// point_segment_distance_sq_top
// squared distance from a point to a line segment, fixed-point pipeline
// ----------------------------------------------------------------------------
// Fully pipelined: a transaction is taken on every cycle (busy stays low) and
// its result appears on out_valid after the edge that accepted start, in
// order; the input register loads at that edge. The pipeline is the row of
// FRAC_BITS division cells, one quotient bit per cell, between four front
// stages (input, deltas, products, sums) and four back stages (t times delta,
// offset, squares, output). The receiver cannot stall; every result is shown
// for exactly one cycle and must be taken then.
// ----------------------------------------------------------------------------
module point_segment_distance_sq_top #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = psd_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  in_point_x,
  input  logic signed [COORD_BITS-1:0]  in_point_y,
  input  logic signed [COORD_BITS-1:0]  in_start_x,
  input  logic signed [COORD_BITS-1:0]  in_start_y,
  input  logic signed [COORD_BITS-1:0]  in_end_x,
  input  logic signed [COORD_BITS-1:0]  in_end_y,
  output logic                          out_valid,
  output logic [psd_pkg::DIST_W-1:0]    out_dist_sq,
  output logic [psd_pkg::PROJ_W-1:0]    out_proj_factor,
  output logic                          out_degenerate
);

  localparam int DW   = COORD_BITS + 1;
  localparam int L2W  = 2 * COORD_BITS + 2;
  localparam int DOTW = 2 * COORD_BITS + 3;
  localparam int TW   = FRAC_BITS + 1;
  localparam int PW   = TW + 1 + DW;
  localparam int EW   = FRAC_BITS + DW + 2;
  localparam int SW   = 2 * EW + 1;
  localparam int DIST_W = psd_pkg::DIST_W;
  localparam int PROJ_W = psd_pkg::PROJ_W;

  psd_pkg::psd_ctrl_t ctrl_s1_r, ctrl_s2_r, ctrl_s3_r;
  logic s0_valid_r;

  // stage 0: input capture
  logic signed [COORD_BITS-1:0] px_r, py_r, ax_r, ay_r, bx_r, by_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= in_point_x;
    py_r <= in_point_y;
    ax_r <= in_start_x;
    ay_r <= in_start_y;
    bx_r <= in_end_x;
    by_r <= in_end_y;
  end

  // stage 1: deltas
  logic signed [DW-1:0] dx_s1_r, dy_s1_r, apx_s1_r, apy_s1_r;

  always_ff @(posedge clk) begin
    dx_s1_r  <= DW'(bx_r) - DW'(ax_r);
    dy_s1_r  <= DW'(by_r) - DW'(ay_r);
    apx_s1_r <= DW'(px_r) - DW'(ax_r);
    apy_s1_r <= DW'(py_r) - DW'(ay_r);
  end

  // stage 2: products
  logic signed [2*DW-1:0] dxx_r, dyy_r, adx_r, ady_r, axx_r, ayy_r;
  logic signed [DW-1:0]   dx_s2_r, dy_s2_r, apx_s2_r, apy_s2_r;

  always_ff @(posedge clk) begin
    dxx_r    <= (2*DW)'(dx_s1_r) * (2*DW)'(dx_s1_r);
    dyy_r    <= (2*DW)'(dy_s1_r) * (2*DW)'(dy_s1_r);
    adx_r    <= (2*DW)'(apx_s1_r) * (2*DW)'(dx_s1_r);
    ady_r    <= (2*DW)'(apy_s1_r) * (2*DW)'(dy_s1_r);
    axx_r    <= (2*DW)'(apx_s1_r) * (2*DW)'(apx_s1_r);
    ayy_r    <= (2*DW)'(apy_s1_r) * (2*DW)'(apy_s1_r);
    dx_s2_r  <= dx_s1_r;
    dy_s2_r  <= dy_s1_r;
    apx_s2_r <= apx_s1_r;
    apy_s2_r <= apy_s1_r;
  end

  // stage 3: length, dot product, clamp decisions
  logic [L2W-1:0]         l2_c, dsq_c;
  logic signed [DOTW-1:0] dot_c;
  logic [L2W-1:0]         l2_s3_r, dsq_s3_r, rem_s3_r;
  logic signed [DW-1:0]   dx_s3_r, dy_s3_r, apx_s3_r, apy_s3_r;
  psd_pkg::psd_ctrl_t     ctrl_s3_nxt;

  always_comb begin
    l2_c  = L2W'(dxx_r) + L2W'(dyy_r);
    dsq_c = L2W'(axx_r) + L2W'(ayy_r);
    dot_c = DOTW'(adx_r) + DOTW'(ady_r);
    ctrl_s3_nxt.valid    = ctrl_s2_r.valid;
    ctrl_s3_nxt.degen    = (l2_c == '0);
    ctrl_s3_nxt.clamp_lo = (l2_c == '0) || (dot_c <= 0);
    ctrl_s3_nxt.clamp_hi = (l2_c != '0) && (dot_c >= $signed({1'b0, l2_c}));
  end

  always_ff @(posedge clk) begin
    l2_s3_r  <= l2_c;
    dsq_s3_r <= dsq_c;
    rem_s3_r <= dot_c[L2W-1:0];
    dx_s3_r  <= dx_s2_r;
    dy_s3_r  <= dy_s2_r;
    apx_s3_r <= apx_s2_r;
    apy_s3_r <= apy_s2_r;
  end

  // control pipe through the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_s1_r <= '0;
      ctrl_s2_r <= '0;
      ctrl_s3_r <= '0;
    end else begin
      ctrl_s1_r <= '{valid: s0_valid_r, default: 1'b0};
      ctrl_s2_r <= ctrl_s1_r;
      ctrl_s3_r <= ctrl_s3_nxt;
    end
  end

  // row of division cells, one quotient bit each
  psd_pkg::psd_ctrl_t    ctrl_a [0:FRAC_BITS];
  logic [L2W-1:0]        rem_a  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]  quo_a  [0:FRAC_BITS];
  logic [L2W-1:0]        l2_a   [0:FRAC_BITS];
  logic [L2W-1:0]        dsq_a  [0:FRAC_BITS];
  logic signed [DW-1:0]  dx_a   [0:FRAC_BITS];
  logic signed [DW-1:0]  dy_a   [0:FRAC_BITS];
  logic signed [DW-1:0]  apx_a  [0:FRAC_BITS];
  logic signed [DW-1:0]  apy_a  [0:FRAC_BITS];

  assign ctrl_a[0] = ctrl_s3_r;
  assign rem_a[0]  = rem_s3_r;
  assign quo_a[0]  = '0;
  assign l2_a[0]   = l2_s3_r;
  assign dsq_a[0]  = dsq_s3_r;
  assign dx_a[0]   = dx_s3_r;
  assign dy_a[0]   = dy_s3_r;
  assign apx_a[0]  = apx_s3_r;
  assign apy_a[0]  = apy_s3_r;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
    psd_div_cell #(
      .FRAC_BITS (FRAC_BITS),
      .DW        (DW),
      .L2W       (L2W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl_i (ctrl_a[i]),
      .rem_i  (rem_a[i]),
      .quo_i  (quo_a[i]),
      .l2_i   (l2_a[i]),
      .dsq_i  (dsq_a[i]),
      .dx_i   (dx_a[i]),
      .dy_i   (dy_a[i]),
      .apx_i  (apx_a[i]),
      .apy_i  (apy_a[i]),
      .ctrl_o (ctrl_a[i+1]),
      .rem_o  (rem_a[i+1]),
      .quo_o  (quo_a[i+1]),
      .l2_o   (l2_a[i+1]),
      .dsq_o  (dsq_a[i+1]),
      .dx_o   (dx_a[i+1]),
      .dy_o   (dy_a[i+1]),
      .apx_o  (apx_a[i+1]),
      .apy_o  (apy_a[i+1])
    );
  end

  // back stage 1: clamp t, multiply by the deltas
  psd_pkg::psd_ctrl_t   ctrl_q;
  logic [TW-1:0]        t_c;
  logic [TW-1:0]        t_b1_r, t_b2_r, t_b3_r;
  logic signed [PW-1:0] tdx_r, tdy_r;
  logic signed [EW-1:0] apxs_r, apys_r;
  logic [L2W-1:0]       dsq_b1_r, dsq_b2_r, dsq_b3_r;

  assign ctrl_q = ctrl_a[FRAC_BITS];

  always_comb begin
    priority if (ctrl_q.clamp_lo) begin
      t_c = '0;
    end else if (ctrl_q.clamp_hi) begin
      t_c = TW'(1) << FRAC_BITS;
    end else begin
      t_c = {1'b0, quo_a[FRAC_BITS]};
    end
  end

  always_ff @(posedge clk) begin
    t_b1_r   <= t_c;
    tdx_r    <= PW'($signed({1'b0, t_c})) * PW'(dx_a[FRAC_BITS]);
    tdy_r    <= PW'($signed({1'b0, t_c})) * PW'(dy_a[FRAC_BITS]);
    apxs_r   <= EW'(apx_a[FRAC_BITS]) <<< FRAC_BITS;
    apys_r   <= EW'(apy_a[FRAC_BITS]) <<< FRAC_BITS;
    dsq_b1_r <= dsq_a[FRAC_BITS];
  end

  // back stage 2: offset from the projected point
  logic signed [EW-1:0] ex_r, ey_r;

  always_ff @(posedge clk) begin
    ex_r     <= apxs_r - EW'(tdx_r);
    ey_r     <= apys_r - EW'(tdy_r);
    t_b2_r   <= t_b1_r;
    dsq_b2_r <= dsq_b1_r;
  end

  // back stage 3: squares
  logic signed [2*EW-1:0] ex2_r, ey2_r;

  always_ff @(posedge clk) begin
    ex2_r    <= (2*EW)'(ex_r) * (2*EW)'(ex_r);
    ey2_r    <= (2*EW)'(ey_r) * (2*EW)'(ey_r);
    t_b3_r   <= t_b2_r;
    dsq_b3_r <= dsq_b2_r;
  end

  // back stage 4: sum (start-point distance if degenerate), truncate to the output format
  logic [SW-1:0]                   sum_c;
  logic [SW+DIST_W-1:0]            sum_sh_c;
  logic [L2W+FRAC_BITS+DIST_W-1:0] dsq_sh_c;
  logic [TW+PROJ_W-1:0]            t_ext_c;
  psd_pkg::psd_ctrl_t              ctrl_b1_r, ctrl_b2_r, ctrl_b3_r;

  always_comb begin
    sum_c    = SW'(unsigned'(ex2_r)) + SW'(unsigned'(ey2_r));
    sum_sh_c = (SW+DIST_W)'(sum_c) >> FRAC_BITS;
    dsq_sh_c = (L2W+FRAC_BITS+DIST_W)'(dsq_b3_r) << FRAC_BITS;
    t_ext_c  = (TW+PROJ_W)'(t_b3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_b1_r <= '0;
      ctrl_b2_r <= '0;
      ctrl_b3_r <= '0;
      out_valid <= 1'b0;
    end else begin
      ctrl_b1_r <= ctrl_q;
      ctrl_b2_r <= ctrl_b1_r;
      ctrl_b3_r <= ctrl_b2_r;
      out_valid <= ctrl_b3_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_dist_sq     <= ctrl_b3_r.degen ? dsq_sh_c[DIST_W-1:0] : sum_sh_c[DIST_W-1:0];
    out_proj_factor <= t_ext_c[PROJ_W-1:0];
    out_degenerate  <= ctrl_b3_r.degen;
  end

endmodule

// File: design/psd_div_cell.sv
// ----------------------------------------------------------------------------
// psd_div_cell
// one restoring-division cell: adds one quotient bit and passes the
// transaction on to the next cell
// ----------------------------------------------------------------------------
module psd_div_cell #(
  parameter int FRAC_BITS = psd_pkg::FRAC_BITS_DEF,
  parameter int DW        = 13,
  parameter int L2W       = 26
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psd_pkg::psd_ctrl_t    ctrl_i,
  input  logic [L2W-1:0]        rem_i,
  input  logic [FRAC_BITS-1:0]  quo_i,
  input  logic [L2W-1:0]        l2_i,
  input  logic [L2W-1:0]        dsq_i,
  input  logic signed [DW-1:0]  dx_i,
  input  logic signed [DW-1:0]  dy_i,
  input  logic signed [DW-1:0]  apx_i,
  input  logic signed [DW-1:0]  apy_i,
  output psd_pkg::psd_ctrl_t    ctrl_o,
  output logic [L2W-1:0]        rem_o,
  output logic [FRAC_BITS-1:0]  quo_o,
  output logic [L2W-1:0]        l2_o,
  output logic [L2W-1:0]        dsq_o,
  output logic signed [DW-1:0]  dx_o,
  output logic signed [DW-1:0]  dy_o,
  output logic signed [DW-1:0]  apx_o,
  output logic signed [DW-1:0]  apy_o
);

  psd_pkg::psd_ctrl_t    ctrl_r;
  logic [L2W-1:0]        rem_r, rem_nxt;
  logic [FRAC_BITS-1:0]  quo_r, quo_nxt;
  logic [L2W-1:0]        l2_r, dsq_r;
  logic signed [DW-1:0]  dx_r, dy_r, apx_r, apy_r;
  logic [L2W:0]          rem2, diff;
  logic                  ge;

  // shift remainder, trial subtract
  always_comb begin
    rem2    = {rem_i, 1'b0};
    diff    = rem2 - {1'b0, l2_i};
    ge      = (rem2 >= {1'b0, l2_i});
    rem_nxt = ge ? diff[L2W-1:0] : rem2[L2W-1:0];
    quo_nxt = {quo_i[FRAC_BITS-2:0], ge};
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_i;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    l2_r  <= l2_i;
    dsq_r <= dsq_i;
    dx_r  <= dx_i;
    dy_r  <= dy_i;
    apx_r <= apx_i;
    apy_r <= apy_i;
  end

  assign ctrl_o = ctrl_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign l2_o   = l2_r;
  assign dsq_o  = dsq_r;
  assign dx_o   = dx_r;
  assign dy_o   = dy_r;
  assign apx_o  = apx_r;
  assign apy_o  = apy_r;

endmodule

// File: tb/point_segment_distance_sq_top_test.sv
// ----------------------------------------------------------------------------
// point_segment_distance_sq_top_test
// drives points and segments into the distance pipeline and compares every
// result against a fixed-point predictor of the squared distance
// ----------------------------------------------------------------------------
module point_segment_distance_sq_top_test;

  localparam int CB = psd_pkg::COORD_BITS_DEF;
  localparam int FB = psd_pkg::FRAC_BITS_DEF;
  localparam int DIST_W = psd_pkg::DIST_W;
  localparam int PROJ_W = psd_pkg::PROJ_W;
  localparam int LATENCY = FB + 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_sq;
    logic [PROJ_W-1:0] proj;
    logic              degen;
  } dist_result_t;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  coord_t in_point_x, in_point_y, in_start_x, in_start_y, in_end_x, in_end_y;
  logic   out_valid;
  logic [DIST_W-1:0] out_dist_sq;
  logic [PROJ_W-1:0] out_proj_factor;
  logic   out_degenerate;

  dist_result_t expected_q[$];
  int     mismatch_count;
  int     idle_cycles;
  bit     timed_out;
  bit     allow_gaps;

  point_segment_distance_sq_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_dist_sq(out_dist_sq),
    .out_proj_factor(out_proj_factor), .out_degenerate(out_degenerate)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected squared distance to the nearest segment point
  function automatic dist_result_t nearest_dist_sq(coord_t px, coord_t py, coord_t ax,
                                                   coord_t ay, coord_t bx, coord_t by);
    longint dx, dy, apx, apy, len_sq, dot, t, ex, ey;
    logic [127:0] sum;
    dist_result_t r;
    dx = longint'(bx) - longint'(ax);
    dy = longint'(by) - longint'(ay);
    apx = longint'(px) - longint'(ax);
    apy = longint'(py) - longint'(ay);
    len_sq = dx * dx + dy * dy;
    if (len_sq == 0) begin
      sum = 128'(apx * apx + apy * apy) << FB;
      r.dist_sq = sum[DIST_W-1:0];
      r.proj = '0;
      r.degen = 1'b1;
      return r;
    end
    dot = apx * dx + apy * dy;
    if (dot <= 0) t = 0;
    else if (dot >= len_sq) t = longint'(1) << FB;
    else t = (dot << FB) / len_sq;
    ex = (apx << FB) - t * dx;
    ey = (apy << FB) - t * dy;
    if (ex < 0) ex = -ex;
    if (ey < 0) ey = -ey;
    sum = 128'(ex) * 128'(ex) + 128'(ey) * 128'(ey);
    sum = sum >> FB;
    r.dist_sq = sum[DIST_W-1:0];
    r.proj = t[PROJ_W-1:0];
    r.degen = 1'b0;
    return r;
  endfunction

  // send one transaction, with an optional random gap first
  task automatic send_query(coord_t px, coord_t py, coord_t ax, coord_t ay,
                            coord_t bx, coord_t by);
    int gap;
    gap = 0;
    if (allow_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_point_x <= px; in_point_y <= py;
    in_start_x <= ax; in_start_y <= ay;
    in_end_x <= bx; in_end_y <= by;
    do @(posedge clk); while (busy);
    expected_q.push_back(nearest_dist_sq(px, py, ax, ay, bx, by));
    @(negedge clk);
  endtask

  // same as send_query, taking plain integer coordinates
  task automatic send_int_query(int px, int py, int ax, int ay, int bx, int by);
    send_query(coord_t'(px), coord_t'(py), coord_t'(ax), coord_t'(ay),
               coord_t'(bx), coord_t'(by));
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t near_coord(coord_t base);
    return coord_t'(int'(base) + $urandom_range(0, 6) - 3);
  endfunction

  // extremes, coincident endpoints, both clamps and interior projections
  task automatic test_directed();
    int mx, mn;
    mx = 2047;
    mn = -2048;
    send_int_query(mx, mx, mn, mn, mn, mn);
    send_int_query(mn, mn, mx, mx, mx, mx);
    send_int_query(mx, mn, mn, mx, mn, mx);
    send_int_query(0, 0, 0, 0, 0, 0);
    send_int_query(mn, mn, 0, 0, 10, 0);
    send_int_query(-5, 3, 0, 0, 10, 0);
    send_int_query(0, 7, 0, 0, 10, 0);
    send_int_query(10, 7, 0, 0, 10, 0);
    send_int_query(mx, mx, 0, 0, 10, 0);
    send_int_query(5, 9, 0, 0, 10, 0);
    send_int_query(3, 1, 0, 0, 7, 3);
    send_int_query(mx, mn, mn, mn, mx, mx);
    send_int_query(mn, mx, mn, mn, mx, mx);
    send_int_query(mx, mx, mn, mx, mx, mn);
    send_int_query(0, 0, mn, mn, mx, mx);
    send_int_query(mn, mx, mx, mn, mn, mx);
    send_int_query(1, 1, 0, 0, 1, 0);
    send_int_query(-1, -1, -1, -1, 0, -1);
    send_query(coord_t'(12'haaa), coord_t'(12'h555), coord_t'(12'h555),
               coord_t'(12'haaa), coord_t'(12'haaa), coord_t'(12'h555));
    send_query(coord_t'(12'h555), coord_t'(12'haaa), coord_t'(12'haaa),
               coord_t'(12'h555), coord_t'(12'h555), coord_t'(12'haaa));
    stop_sending();
  endtask

  // hold off until the pipeline has drained completely
  task automatic test_drain_pause();
    send_int_query(100, -200, -300, 400, 500, -600);
    stop_sending();
    while (expected_q.size() != 0 && !timed_out) @(negedge clk);
    send_int_query(-7, 8, 9, -10, 11, 12);
    stop_sending();
  endtask

  // random mix of full-range, short and degenerate segments
  task automatic test_random(int count);
    coord_t ax, ay;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      ax = rand_coord();
      ay = rand_coord();
      case (kind)
        0: send_query(rand_coord(), rand_coord(), ax, ay, ax, ay);
        1, 2: send_query(rand_coord(), rand_coord(), ax, ay, near_coord(ax), near_coord(ay));
        3: send_query(near_coord(ax), near_coord(ay), ax, ay, rand_coord(), rand_coord());
        default: send_query(rand_coord(), rand_coord(), ax, ay, rand_coord(), rand_coord());
      endcase
    end
    stop_sending();
  endtask

  // result checker
  always @(posedge clk) begin
    dist_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: dist_sq=%0d proj=%0d degen=%0b",
                   out_dist_sq, out_proj_factor, out_degenerate);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_dist_sq !== exp_r.dist_sq || out_proj_factor !== exp_r.proj ||
            out_degenerate !== exp_r.degen) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: dist_sq exp %0d got %0d, proj exp %0d got %0d, degen exp %0b got %0b",
                     exp_r.dist_sq, out_dist_sq, exp_r.proj, out_proj_factor,
                     exp_r.degen, out_degenerate);
        end
      end
    end
  end

  // watchdog on cycles with no accepted transaction and no result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1'b1;
      $display("tb: failure");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_point_x = '0; in_point_y = '0;
    in_start_x = '0; in_start_y = '0;
    in_end_x = '0; in_end_y = '0;
    mismatch_count = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    allow_gaps = 1'b1;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_drain_pause();
    test_random(600);
    allow_gaps = 1'b0;
    test_random(200);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
